FILE: src/cpu_tick_scheduler_macros.svh
// Assertion macros for the tick scheduler checker
`ifndef CPU_TICK_SCHEDULER_MACROS_SVH
`define CPU_TICK_SCHEDULER_MACROS_SVH

// Implication in the same cycle
`define CTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication in the next cycle
`define CTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: src/cts_pkg.sv
`timescale 1ns / 1ps
package cts_pkg;

	localparam int TABLE_SLOTS_DEF = 16;

	// scheduling modes
	localparam logic [2:0] MODE_FCFS = 3'd0;
	localparam logic [2:0] MODE_SJF  = 3'd1;
	localparam logic [2:0] MODE_SRTF = 3'd2;
	localparam logic [2:0] MODE_PRIP = 3'd3;
	localparam logic [2:0] MODE_PRIN = 3'd4;
	localparam logic [2:0] MODE_RR   = 3'd5;

	// result kinds
	localparam logic [2:0] KIND_ACCEPT = 3'd0;
	localparam logic [2:0] KIND_REJECT = 3'd1;
	localparam logic [2:0] KIND_IDLE   = 3'd2;
	localparam logic [2:0] KIND_RAN    = 3'd3;
	localparam logic [2:0] KIND_FINISH = 3'd4;

	// command codes
	localparam logic CMD_ARRIVAL = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// configuration register indexes
	localparam logic REG_MODE    = 1'b0;
	localparam logic REG_QUANTUM = 1'b1;

	localparam logic [15:0] TIME_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  pid;
		logic [7:0]  left;
		logic [7:0]  burst;
		logic [7:0]  prio;
		logic [15:0] arrival;
		logic [15:0] order;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARR,
		ST_SCAN,
		ST_SCAN_END,
		ST_RD,
		ST_RD_WAIT,
		ST_UPD
	} state_t;

	// selection key of an entry for the given mode
	function automatic logic [7:0] sort_key(input logic [2:0] mode, input entry_t e);
		logic [7:0] k;
		case (mode)
			MODE_SJF:            k = e.burst;
			MODE_SRTF:           k = e.left;
			MODE_PRIP, MODE_PRIN: k = e.prio;
			default:             k = 8'd0;
		endcase
		return k;
	endfunction

endpackage

FILE: src/cpu_tick_scheduler.sv
`timescale 1ns / 1ps
// Arrival: a zero burst is rejected straight from idle, else a free-entry search runs over
// the table. Tick: a new pick scans the table (an idle slot also ends after the scan),
// while a kept running process is read back through ST_RD and ST_RD_WAIT; the scan reads one
// entry per cycle from the single read port of the table RAM. One item at a time; the result is shown
// for one cycle on done and cannot be stalled. Reset is asynchronous, active low: table
// empty, time and order zero, mode fcfs, quantum 2.
module cpu_tick_scheduler #(
	parameter int TABLE_SLOTS = cts_pkg::TABLE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [7:0]  proc_id,
	input  logic [7:0]  burst_len,
	input  logic [7:0]  prio_level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic [2:0]  result_kind,
	output logic [7:0]  run_id,
	output logic [15:0] finish_time,
	output logic [15:0] turnaround,
	output logic [15:0] waiting
);

	import cts_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [IDX_W:0]   NONE     = (IDX_W+1)'(TABLE_SLOTS);

	state_t state_q, state_nx;

	logic [2:0]  mode_q;
	logic [7:0]  quantum_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [IDX_W:0] running_q;
	logic [7:0]  slice_q;
	logic [15:0] now_q, order_q;
	logic [7:0]  pid_q, burst_q, prio_q;

	logic [IDX_W-1:0] scan_q, scan_idx_s1;
	logic             scan_vld_s1;
	logic             best_found_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t           best_ent_q;

	logic [IDX_W-1:0] cur_q;
	entry_t           ent_q;
	logic             slice_clr_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;

	logic [2:0] mode_eff;
	logic       keep_run;
	logic       accept;
	logic       free_hit;

	cts_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign mode_eff  = (mode_q > MODE_RR) ? MODE_FCFS : mode_q;
	assign keep_run  = (mode_eff == MODE_FCFS || mode_eff == MODE_SJF ||
		mode_eff == MODE_PRIN || mode_eff == MODE_RR) && running_q != NONE &&
		valid_q[running_q[IDX_W-1:0]];
	assign free_hit  = !valid_q[scan_q];

	// compare the entry read last cycle against the best so far
	logic             found_nx;
	logic [IDX_W-1:0] idx_nx;
	entry_t           bent_nx;
	always_comb begin
		logic [7:0] ka, kb;
		ka = sort_key(mode_eff, ram_rdata);
		kb = sort_key(mode_eff, best_ent_q);
		found_nx = best_found_q;
		idx_nx   = best_idx_q;
		bent_nx  = best_ent_q;
		if (scan_vld_s1 && (!best_found_q || ka < kb ||
			(ka == kb && ram_rdata.order < best_ent_q.order))) begin
			found_nx = 1'b1;
			idx_nx   = scan_idx_s1;
			bent_nx  = ram_rdata;
		end
	end

	// tick update arithmetic
	logic [7:0]  left_nx, slice_base, slice_inc, q_eff;
	logic [15:0] now_nx, order_nx, tat, wt;
	logic        fin_now, rr_turn;
	always_comb begin
		now_nx     = (now_q == TIME_MAX) ? now_q : now_q + 16'd1;
		order_nx   = (order_q == TIME_MAX) ? order_q : order_q + 16'd1;
		left_nx    = (ent_q.left != 8'd0) ? ent_q.left - 8'd1 : ent_q.left;
		fin_now    = (left_nx == 8'd0);
		tat        = (now_nx >= ent_q.arrival) ? now_nx - ent_q.arrival : 16'd0;
		wt         = (tat >= {8'd0, ent_q.burst}) ? tat - {8'd0, ent_q.burst} : 16'd0;
		slice_base = slice_clr_q ? 8'd0 : slice_q;
		slice_inc  = (slice_base < 8'hFF) ? slice_base + 8'd1 : slice_base;
		q_eff      = (quantum_q == 8'd0) ? 8'd1 : quantum_q;
		rr_turn    = (mode_eff == MODE_RR) && (slice_inc >= q_eff);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_ARRIVAL) begin
						state_nx = (burst_len == 8'd0) ? ST_IDLE : ST_ARR;
					end else begin
						state_nx = keep_run ? ST_RD : ST_SCAN;
					end
				end
			end
			ST_ARR:      state_nx = (free_hit || scan_q == LAST_IDX) ? ST_IDLE : ST_ARR;
			ST_SCAN:     state_nx = (scan_q == LAST_IDX) ? ST_SCAN_END : ST_SCAN;
			ST_SCAN_END: state_nx = found_nx ? ST_UPD : ST_IDLE;
			ST_RD:       state_nx = ST_RD_WAIT;
			ST_RD_WAIT:  state_nx = ST_UPD;
			ST_UPD:      state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	// control outputs and table port
	always_comb begin
		busy      = (state_q != ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = scan_q;
		ram_wdata = ent_q;
		ram_raddr = scan_q;
		unique case (state_q)
			ST_ARR: begin
				ram_we    = free_hit;
				ram_wdata = '{pid: pid_q, left: burst_q, burst: burst_q, prio: prio_q,
					arrival: now_q, order: order_q};
			end
			ST_RD: begin
				ram_raddr = running_q[IDX_W-1:0];
			end
			ST_UPD: begin
				ram_we          = !fin_now;
				ram_waddr       = cur_q;
				ram_wdata.left  = left_nx;
				ram_wdata.order = rr_turn ? order_q : ent_q.order;
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_FCFS;
			quantum_q <= 8'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:    mode_q    <= cfg_data[2:0];
				REG_QUANTUM: quantum_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pid_q   <= proc_id;
			burst_q <= burst_len;
			prio_q  <= prio_level;
		end
		scan_idx_s1 <= scan_q;
		best_idx_q  <= idx_nx;
		best_ent_q  <= bent_nx;
		if (state_q == ST_SCAN_END) begin
			cur_q <= idx_nx;
			ent_q <= bent_nx;
		end else if (state_q == ST_RD_WAIT) begin
			ent_q <= ram_rdata;
		end
		if (state_q == ST_IDLE) begin
			cur_q <= running_q[IDX_W-1:0];
		end
	end

	// control state, scheduler state and result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			running_q    <= NONE;
			slice_q      <= 8'd0;
			now_q        <= 16'd0;
			order_q      <= 16'd0;
			scan_q       <= '0;
			scan_vld_s1  <= 1'b0;
			best_found_q <= 1'b0;
			slice_clr_q  <= 1'b0;
			done         <= 1'b0;
			result_kind  <= KIND_ACCEPT;
			run_id       <= 8'd0;
			finish_time  <= 16'd0;
			turnaround   <= 16'd0;
			waiting      <= 16'd0;
		end else begin
			state_q     <= state_nx;
			done        <= 1'b0;
			scan_vld_s1 <= (state_q == ST_SCAN) && valid_q[scan_q];
			best_found_q <= (state_q == ST_IDLE) ? 1'b0 : found_nx;
			unique case (state_q)
				ST_IDLE: begin
					scan_q       <= '0;
					slice_clr_q  <= 1'b0;
					if (accept && cmd == CMD_ARRIVAL && burst_len == 8'd0) begin
						done        <= 1'b1;
						result_kind <= KIND_REJECT;
						run_id      <= proc_id;
						finish_time <= 16'd0;
						turnaround  <= 16'd0;
						waiting     <= 16'd0;
					end
				end
				ST_ARR: begin
					scan_q <= scan_q + IDX_W'(1);
					if (free_hit || scan_q == LAST_IDX) begin
						done        <= 1'b1;
						result_kind <= free_hit ? KIND_ACCEPT : KIND_REJECT;
						run_id      <= pid_q;
						finish_time <= 16'd0;
						turnaround  <= 16'd0;
						waiting     <= 16'd0;
					end
					if (free_hit) begin
						valid_q[scan_q] <= 1'b1;
						order_q         <= order_nx;
					end
				end
				ST_SCAN: begin
					if (scan_q != LAST_IDX) begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				ST_SCAN_END: begin
					slice_clr_q <= ({1'b0, idx_nx} != running_q);
					if (!found_nx) begin
						now_q       <= now_nx;
						running_q   <= NONE;
						slice_q     <= 8'd0;
						done        <= 1'b1;
						result_kind <= KIND_IDLE;
						run_id      <= 8'd0;
						finish_time <= 16'd0;
						turnaround  <= 16'd0;
						waiting     <= 16'd0;
					end
				end
				ST_UPD: begin
					now_q  <= now_nx;
					done   <= 1'b1;
					run_id <= ent_q.pid;
					if (fin_now) begin
						valid_q[cur_q] <= 1'b0;
						running_q      <= NONE;
						slice_q        <= 8'd0;
						result_kind    <= KIND_FINISH;
						finish_time    <= now_nx;
						turnaround     <= tat;
						waiting        <= wt;
					end else begin
						result_kind <= KIND_RAN;
						finish_time <= 16'd0;
						turnaround  <= 16'd0;
						waiting     <= 16'd0;
						if (rr_turn) begin
							order_q   <= order_nx;
							running_q <= NONE;
							slice_q   <= 8'd0;
						end else begin
							running_q <= {1'b0, cur_q};
							slice_q   <= (mode_eff == MODE_RR) ? slice_inc : slice_base;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: src/cts_ram.sv
`timescale 1ns / 1ps
module cts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/cts_checker.sv
`timescale 1ns / 1ps
`include "cpu_tick_scheduler_macros.svh"
module cts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        cmd,
	input logic [7:0]  burst_len,
	input logic        done,
	input logic [2:0]  result_kind,
	input logic [15:0] finish_time,
	input logic [15:0] turnaround,
	input logic [15:0] waiting
);

	import cts_pkg::*;

	// every accepted item either keeps the block working or reports at once
	`CTS_ASSERT_NEXT(a_item_progress, start && !busy, busy || done)

	// a zero-burst arrival is rejected in the following cycle
	`CTS_ASSERT_NEXT(a_zero_reject, start && !busy && cmd == CMD_ARRIVAL && burst_len == 8'd0,
		done && result_kind == KIND_REJECT)

	// timing fields only carry values on completion
	`CTS_ASSERT_NOW(a_times_zero, done && result_kind != KIND_FINISH,
		finish_time == 16'd0 && turnaround == 16'd0 && waiting == 16'd0)

	// waiting never exceeds turnaround, and turnaround never exceeds finish time
	`CTS_ASSERT_NOW(a_time_order, done && result_kind == KIND_FINISH,
		waiting <= turnaround && turnaround <= finish_time && finish_time != 16'd0)

endmodule

bind cpu_tick_scheduler cts_checker u_cts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.cmd        (cmd),
	.burst_len  (burst_len),
	.done       (done),
	.result_kind(result_kind),
	.finish_time(finish_time),
	.turnaround (turnaround),
	.waiting    (waiting)
);
